// ===== hw/rtl/mdof_pkg.sv =====
// ----------------------------------------------------------------------------
// mdof_pkg
// shared types and constants of the decode and operand fetch block
// ----------------------------------------------------------------------------
package mdof_pkg;

  localparam int unsigned NumCmd = 21;
  localparam logic [4:0] CmdUnknown = 5'd20;

  localparam logic [1:0] KindLoad   = 2'd0;
  localparam logic [1:0] KindRegWr  = 2'd1;
  localparam logic [1:0] KindDecode = 2'd2;

  // parameter bits of a table entry
  typedef struct packed {
    logic xx;
    logic nn;
    logic rlo;
    logic rhi;
    logic dst;
    logic src;
  } cmd_params_t;

  typedef struct packed {
    logic [15:0] mask;
    logic [15:0] code;
    cmd_params_t params;
  } cmd_entry_t;

  function automatic cmd_entry_t cmd_entry(input logic [4:0] idx);
    cmd_entry_t e;
    e = '{mask: 16'o0, code: 16'o0, params: 6'b000000};
    unique case (idx)
      5'd0:  e = '{16'o170000, 16'o060000, 6'b000011};
      5'd1:  e = '{16'o170000, 16'o010000, 6'b000011};
      5'd2:  e = '{16'o177777, 16'o000000, 6'b000000};
      5'd3:  e = '{16'o177000, 16'o077000, 6'b010100};
      5'd4:  e = '{16'o170000, 16'o110000, 6'b000011};
      5'd5:  e = '{16'o177400, 16'o000400, 6'b100000};
      5'd6:  e = '{16'o177400, 16'o103000, 6'b100000};
      5'd7:  e = '{16'o177400, 16'o103400, 6'b100000};
      5'd8:  e = '{16'o177400, 16'o001400, 6'b100000};
      5'd9:  e = '{16'o177400, 16'o100400, 6'b100000};
      5'd10: e = '{16'o177400, 16'o001000, 6'b100000};
      5'd11: e = '{16'o177400, 16'o100000, 6'b100000};
      5'd12: e = '{16'o177700, 16'o005700, 6'b000010};
      5'd13: e = '{16'o177700, 16'o105700, 6'b000010};
      5'd14: e = '{16'o170000, 16'o120000, 6'b000011};
      5'd15: e = '{16'o170000, 16'o020000, 6'b000011};
      5'd16: e = '{16'o177000, 16'o005000, 6'b000010};
      5'd17: e = '{16'o177000, 16'o105000, 6'b000010};
      5'd18: e = '{16'o177000, 16'o004000, 6'b000110};
      5'd19: e = '{16'o177770, 16'o000200, 6'b001000};
      default: e = '{16'o000000, 16'o000000, 6'b000000};
    endcase
    return e;
  endfunction

  // result beat
  typedef struct packed {
    logic        mode_error;
    logic [15:0] next_pc;
    logic signed [7:0] branch_offset;
    logic [5:0]  loop_offset;
    logic [2:0]  reg_select;
    logic [15:0] dst_value;
    logic [15:0] dst_addr;
    logic [15:0] src_value;
    logic [15:0] src_addr;
    logic        byte_op;
    logic [4:0]  command_code;
  } result_t;

endpackage

// ===== hw/rtl/minicomputer_decode_operand_fetch.sv =====
// ----------------------------------------------------------------------------
// minicomputer_decode_operand_fetch
// fetch, decode and operand fetch of a 16-bit minicomputer
// ----------------------------------------------------------------------------
// a beat with kind 0 stores a memory word, kind 1 writes a register and kind 2
// fetches the word at pc, decodes it and resolves source then destination
// operand, sending one result beat. a load writes the word and then passes
// through StLoadW; a register write or an ignored kind completes in idle. a
// decode fetches the opcode word, then resolves each operand, with memory
// reads for an index word, a pointer and the operand; most reads are needed
// when both operands use a deferred or index mode. the rate is set by the
// single-port word memory, a read giving the address, then the registered
// data. the register file is eight flip-flop words; r7 is the pc and resets
// to START_ADDR. memory contents are undefined until written. the result sits
// in an output register so the next beat is taken while it waits; a decode
// finishing while the previous result waits holds in its last cycle until free.
module minicomputer_decode_operand_fetch #(
  parameter int unsigned MEM_WORDS  = 32768,
  parameter int unsigned START_ADDR = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // kind[1:0], addr[17:2], data[33:18],
                                 // zero fill[39:34]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [103:0] m_tdata   // command_code, byte_op, src_addr, src_value,
                                 // dst_addr, dst_value, reg_select,
                                 // loop_offset, branch_offset, next_pc,
                                 // mode_error
);
  import mdof_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StFetch  = 4'd1;
  localparam logic [3:0] StOpnd   = 4'd2;
  localparam logic [3:0] StRdWait = 4'd3;
  localparam logic [3:0] StDone   = 4'd4;
  localparam logic [3:0] StLoadW  = 4'd5;

  // operand sub steps
  localparam logic [2:0] RdIndex = 3'd0;
  localparam logic [2:0] RdPtr   = 3'd1;
  localparam logic [2:0] RdVal   = 3'd2;
  localparam logic [2:0] RdInstr = 3'd3;

  logic [15:0] mem [MEM_WORDS];
  logic [15:0] mem_q;
  logic        mem_we;
  logic [AW-1:0] mem_a;
  logic [15:0] mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_a] <= mem_wd;
    end
    mem_q <= mem[mem_a];
  end

  logic [15:0] regs [8];
  logic [3:0]  state;
  logic [2:0]  rd_kind;
  logic [15:0] rd_addr;
  logic        rd_oob;
  logic [15:0] instr;
  cmd_params_t prm;
  logic        phase;      // 0 source, 1 destination
  result_t     res;
  result_t     out_res;
  logic        out_valid;

  logic [1:0]  in_kind;
  logic [15:0] in_addr, in_data;
  assign in_kind = s_tdata[1:0];
  assign in_addr = s_tdata[17:2];
  assign in_data = s_tdata[33:18];

  logic [15:0] mem_q_word;
  assign mem_q_word = rd_oob ? 16'h0000 : mem_q;

  logic [4:0]  dec_cmd;
  cmd_params_t dec_prm;
  mdof_decode u_dec (.word(mem_q_word), .cmd(dec_cmd), .params(dec_prm));

  // current operand field
  logic [5:0]  fld;
  logic [2:0]  fr, fm;
  logic        bop;
  logic [15:0] step;
  assign fld  = phase ? instr[5:0] : instr[11:6];
  assign fr   = fld[2:0];
  assign fm   = fld[5:3];
  assign bop  = instr[15];
  assign step = (bop && fr < 3'd6) ? 16'd1 : 16'd2;

  // operand addresses built from the register of the field
  logic [15:0] idx_sum, dec_step, dec_two;
  assign idx_sum  = regs[fr] + mem_q_word;
  assign dec_step = regs[fr] - step;
  assign dec_two  = regs[fr] - 16'd2;

  logic [15:0] sized;
  assign sized = bop ? (rd_addr[0] ? {8'h00, mem_q_word[15:8]}
                                   : {8'h00, mem_q_word[7:0]}) : mem_q_word;

  // destination still to do after this operand
  logic more_opnd;
  assign more_opnd = !phase && prm.dst;

  // first result fields, straight from the opcode word
  result_t init_res;
  always_comb begin
    init_res = '0;
    init_res.command_code = dec_cmd;
    init_res.byte_op = mem_q_word[15];
    if (dec_prm.rhi) init_res.reg_select = mem_q_word[8:6];
    if (dec_prm.rlo) init_res.reg_select = mem_q_word[2:0];
    if (dec_prm.nn)  init_res.loop_offset = mem_q_word[5:0];
    if (dec_prm.xx)  init_res.branch_offset = mem_q_word[7:0];
  end

  result_t fin_res;
  always_comb begin
    fin_res = res;
    fin_res.next_pc = regs[7];
  end

  // result moves to the output register once that is free
  logic done_fire;
  assign done_fire = (state == StDone) && (!out_valid || m_tready);

  assign s_tready = (state == StIdle);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_res;

  // memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_a  = rd_addr[AW:1];
    mem_wd = in_data;
    if (state == StIdle && s_tvalid && s_tready && in_kind == KindLoad) begin
      mem_a  = in_addr[AW:1];
      mem_we = (32'(in_addr[15:1]) < MEM_WORDS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      out_res <= fin_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      for (int i = 0; i < 8; i++) begin
        regs[i] <= (i == 7) ? 16'(START_ADDR) : 16'h0000;
      end
    end else begin
      unique case (state)
        StIdle: begin
          if (s_tvalid && s_tready) begin
            priority if (in_kind == KindLoad) begin
              state <= StLoadW;
            end else if (in_kind == KindRegWr) begin
              regs[in_addr[2:0]] <= in_data;
            end else if (in_kind == KindDecode) begin
              rd_addr <= regs[7];
              rd_oob  <= 32'(regs[7][15:1]) >= MEM_WORDS;
              rd_kind <= RdInstr;
              state   <= StRdWait;
            end else begin
              state <= StIdle;
            end
          end
        end
        StLoadW: state <= StIdle;
        StRdWait: state <= StFetch;
        StFetch: begin
          // data of the read is on mem_q_word
          unique case (rd_kind)
            RdInstr: begin
              instr <= mem_q_word;
              prm   <= dec_prm;
              regs[7] <= regs[7] + 16'd2;
              res <= init_res;
              phase <= !dec_prm.src;
              state <= (dec_prm.src || dec_prm.dst) ? StOpnd : StDone;
            end
            RdIndex: begin
              rd_addr <= idx_sum;
              rd_oob  <= 32'(idx_sum[15:1]) >= MEM_WORDS;
              if (phase) res.dst_addr <= idx_sum;
              else       res.src_addr <= idx_sum;
              rd_kind <= RdVal;
              state   <= StRdWait;
            end
            RdPtr: begin
              rd_addr <= mem_q_word;
              rd_oob  <= 32'(mem_q_word[15:1]) >= MEM_WORDS;
              if (phase) res.dst_addr <= mem_q_word;
              else       res.src_addr <= mem_q_word;
              rd_kind <= RdVal;
              state   <= StRdWait;
            end
            RdVal: begin
              if (phase) res.dst_value <= sized;
              else       res.src_value <= sized;
              if (more_opnd) phase <= 1'b1;
              state <= more_opnd ? StOpnd : StDone;
            end
            default: state <= StIdle;
          endcase
        end
        StOpnd: begin
          unique case (fm)
            3'd0: begin
              if (phase) begin
                res.dst_addr  <= {13'd0, fr};
                res.dst_value <= bop ? {8'h00, regs[fr][7:0]} : regs[fr];
              end else begin
                res.src_addr  <= {13'd0, fr};
                res.src_value <= bop ? {8'h00, regs[fr][7:0]} : regs[fr];
              end
              if (more_opnd) phase <= 1'b1;
              state <= more_opnd ? StOpnd : StDone;
            end
            3'd1, 3'd2: begin
              rd_addr <= regs[fr];
              rd_oob  <= 32'(regs[fr][15:1]) >= MEM_WORDS;
              if (phase) res.dst_addr <= regs[fr];
              else       res.src_addr <= regs[fr];
              if (fm == 3'd2) regs[fr] <= regs[fr] + step;
              rd_kind <= RdVal;
              state   <= StRdWait;
            end
            3'd3: begin
              rd_addr <= regs[fr];
              rd_oob  <= 32'(regs[fr][15:1]) >= MEM_WORDS;
              regs[fr] <= regs[fr] + 16'd2;
              rd_kind <= RdPtr;
              state   <= StRdWait;
            end
            3'd4: begin
              rd_addr <= dec_step;
              rd_oob  <= 32'(dec_step[15:1]) >= MEM_WORDS;
              if (phase) res.dst_addr <= dec_step;
              else       res.src_addr <= dec_step;
              regs[fr] <= dec_step;
              rd_kind <= RdVal;
              state   <= StRdWait;
            end
            3'd5: begin
              rd_addr <= dec_two;
              rd_oob  <= 32'(dec_two[15:1]) >= MEM_WORDS;
              regs[fr] <= dec_two;
              rd_kind <= RdPtr;
              state   <= StRdWait;
            end
            3'd6: begin
              // index word at pc; the base register is read after pc moves
              rd_addr <= regs[7];
              rd_oob  <= 32'(regs[7][15:1]) >= MEM_WORDS;
              regs[7] <= regs[7] + 16'd2;
              rd_kind <= RdIndex;
              state   <= StRdWait;
            end
            default: begin
              res.mode_error <= 1'b1;
              if (more_opnd) phase <= 1'b1;
              state <= more_opnd ? StOpnd : StDone;
            end
          endcase
        end
        StDone: begin
          if (done_fire) state <= StIdle;
        end
        default: state <= StIdle;
      endcase
    end
  end

endmodule

// ===== hw/rtl/mdof_decode.sv =====
// ----------------------------------------------------------------------------
// mdof_decode
// first-match lookup of an instruction word in the command table
// ----------------------------------------------------------------------------
module mdof_decode (
  input  logic [15:0]          word,
  output logic [4:0]           cmd,
  output mdof_pkg::cmd_params_t params
);
  import mdof_pkg::*;

  always_comb begin
    cmd = CmdUnknown;
    for (int i = NumCmd - 2; i >= 0; i--) begin
      if ((word & cmd_entry(5'(i)).mask) == cmd_entry(5'(i)).code) begin
        cmd = 5'(i);
      end
    end
    params = cmd_entry(cmd).params;
  end

endmodule
